FILE: rtl/core/wrs_pkg.sv
package wrs_pkg;

   localparam int SAMPLE_W = 24;
   localparam int MARGIN_W = 23;
   localparam int DP_W     = 8;
   localparam int DWIN_W   = 5;
   localparam int DLIM_W   = 23;
   localparam int OLIM_W   = 3;
   localparam int DRIFT_W  = 25;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 23;

   localparam int MAX_POINTS_DEF       = 255;
   localparam int MAX_DRIFT_WINDOW_DEF = 16;

   localparam logic [MARGIN_W-1:0] MARGIN_RST = MARGIN_W'(500);
   localparam logic [DP_W-1:0]     DP_RST     = DP_W'(10);
   localparam logic [DWIN_W-1:0]   DWIN_RST   = DWIN_W'(5);
   localparam logic [DLIM_W-1:0]   DLIM_RST   = DLIM_W'(80);
   localparam logic [OLIM_W-1:0]   OLIM_RST   = OLIM_W'(5);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MARGIN        = 3'd0,
      CSR_DATA_POINTS   = 3'd1,
      CSR_DRIFT_WINDOW  = 3'd2,
      CSR_DRIFT_LIMIT   = 3'd3,
      CSR_OUTLIER_LIMIT = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RING,
      ST_DIV,
      ST_FIN
   } state_type;

endpackage

FILE: rtl/core/wrs_ram.sv
module wrs_ram #(
   parameter int WIDTH = wrs_pkg::SAMPLE_W,
   parameter int DEPTH = wrs_pkg::MAX_DRIFT_WINDOW_DEF
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/wrs_div.sv
module wrs_div #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] dividend,
   input  logic        [DEN_W-1:0] divisor,
   output logic                    done,
   output logic signed [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic             neg_ff;
   logic [NUM_W-1:0] quot_ff;

   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_dif;
   logic             ge;
   logic [DEN_W-1:0] rem_nx;
   logic [NUM_W-1:0] num_nx;
   logic [NUM_W-1:0] mag_in;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[NUM_W-1]};
      rem_dif = rem_sh - {1'b0, den_ff};
      ge      = (rem_sh >= {1'b0, den_ff});
      rem_nx  = ge ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      num_nx  = {num_ff[NUM_W-2:0], ge};
      mag_in  = dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= mag_in;
         rem_ff <= '0;
         den_ff <= divisor;
         neg_ff <= dividend[NUM_W-1];
      end else if (busy_ff) begin
         num_ff <= num_nx;
         rem_ff <= rem_nx;
         if (cnt_ff == CNT_W'(1)) begin
            quot_ff <= neg_ff ? (~num_nx + NUM_W'(1)) : num_nx;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = $signed(quot_ff);

endmodule

FILE: rtl/core/weight_reading_stabilizer.sv
// weight reading stabilizer
// req channel: one signed sample per transaction (req_valid, req_stall, req_sample).
// rsp channel: one result per sample (average, stable, sample_rejected,
// stability_lost, drift_detected, drift), handed over with rsp_valid / rsp_stall.
// csr channel: register index and data, csr_ready is always high; write only when idle.
// one sample is in work at a time; req_stall is high from acceptance until the
// result is loaded into the output register.
// a rejected sample goes from acceptance to the finish state and from there into
// the output register. a sample added to the average passes the divide state; a
// sample entering the drift ring passes the ring state and, once the window is
// full, the divide state, which waits on the bit-serial divider, one quotient bit
// per cycle; the divider is NUM_W wide, the wider of the accepted sum and the drift sum.
// the drift ring lives in a ram with a registered read port: the oldest entry is
// read in the accept cycle and the new sample written back in the next one.
// reset clears the running sums, counts and ring pointers and loads the register
// defaults; ring contents are never used before they are written.
// while rsp_stall holds, the result waits in the output register; the next sample
// is still accepted and worked on, and waits for the output register to free.
module weight_reading_stabilizer #(
   parameter int MAX_POINTS       = wrs_pkg::MAX_POINTS_DEF,
   parameter int MAX_DRIFT_WINDOW = wrs_pkg::MAX_DRIFT_WINDOW_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [wrs_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [wrs_pkg::SAMPLE_W-1:0]  rsp_average,
   output logic                                 rsp_stable,
   output logic                                 rsp_sample_rejected,
   output logic                                 rsp_stability_lost,
   output logic                                 rsp_drift_detected,
   output logic signed [wrs_pkg::DRIFT_W-1:0]   rsp_drift,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wrs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [wrs_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int SW      = wrs_pkg::SAMPLE_W;
   localparam int DW      = wrs_pkg::DRIFT_W;
   localparam int CNT_W   = $clog2(MAX_POINTS + 1);
   localparam int SUM_W   = SW + CNT_W;
   localparam int FILL_W  = $clog2(MAX_DRIFT_WINDOW + 1);
   localparam int HEAD_W  = (MAX_DRIFT_WINDOW > 1) ? $clog2(MAX_DRIFT_WINDOW) : 1;
   localparam int IDX_W   = HEAD_W + 1;
   localparam int DSUM_W  = SW + FILL_W;
   localparam int NUM_W   = (SUM_W > DSUM_W) ? SUM_W : DSUM_W;
   localparam int DEN_W   = (CNT_W > FILL_W) ? CNT_W : FILL_W;
   localparam int PCMP_W  = (CNT_W > wrs_pkg::DP_W) ? CNT_W : wrs_pkg::DP_W;
   localparam int WCMP_W  = (FILL_W > wrs_pkg::DWIN_W) ? FILL_W : wrs_pkg::DWIN_W;

   // configuration
   logic [wrs_pkg::MARGIN_W-1:0] margin_ff;
   logic [wrs_pkg::DP_W-1:0]     dpoints_ff;
   logic [wrs_pkg::DWIN_W-1:0]   dwin_ff;
   logic [wrs_pkg::DLIM_W-1:0]   dlimit_ff;
   logic [wrs_pkg::OLIM_W-1:0]   olimit_ff;

   // block state
   wrs_pkg::state_type           state_ff, state_in;
   logic signed [SUM_W-1:0]      sum_ff, sum_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic signed [SW-1:0]         avg_ff, avg_in;
   logic [wrs_pkg::OLIM_W-1:0]   outl_ff, outl_in;
   logic signed [DSUM_W-1:0]     dsum_ff, dsum_in;
   logic [FILL_W-1:0]            fill_ff, fill_in;
   logic [HEAD_W-1:0]            head_ff, head_in;
   logic signed [SW-1:0]         sample_ff, sample_in;

   // per transaction
   logic                         dmode_ff, dmode_in;
   logic                         rej_ff, rej_in;
   logic                         lost_ff, lost_in;
   logic                         det_ff, det_in;
   logic signed [DW-1:0]         dval_ff, dval_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]         rsp_average_ff, rsp_average_in;
   logic                         rsp_stable_ff, rsp_stable_in;
   logic                         rsp_rej_ff, rsp_rej_in;
   logic                         rsp_lost_ff, rsp_lost_in;
   logic                         rsp_det_ff, rsp_det_in;
   logic signed [DW-1:0]         rsp_drift_ff, rsp_drift_in;

   // ring and divider
   logic                         ram_wr_en, ram_rd_en;
   logic [HEAD_W-1:0]            ram_wr_addr;
   logic [SW-1:0]                ram_rd_data;
   logic                         div_start, div_done;
   logic signed [NUM_W-1:0]      div_dividend, div_quotient;
   logic [DEN_W-1:0]             div_divisor;

   // helpers
   logic                         accept;
   logic [PCMP_W-1:0]            pneed;
   logic [WCMP_W-1:0]            wsize;
   logic signed [DW-1:0]         near_diff;
   logic [DW-1:0]                near_mag;
   logic                         near;
   logic [wrs_pkg::OLIM_W:0]     outl_next;
   logic                         remove;
   logic signed [DSUM_W-1:0]     old_entry;
   logic [IDX_W-1:0]             widx;
   logic [HEAD_W-1:0]            head_inc;
   logic signed [SW-1:0]         tail;
   logic signed [SW-1:0]         stab_avg;
   logic signed [DW-1:0]         dcalc;
   logic [DW-1:0]                dmag;
   logic                         out_free;

   always_comb begin
      pneed = PCMP_W'(dpoints_ff);
      if (pneed > PCMP_W'(MAX_POINTS)) begin
         pneed = PCMP_W'(MAX_POINTS);
      end
      wsize = WCMP_W'(dwin_ff);
      if (wsize == '0) begin
         wsize = WCMP_W'(1);
      end else if (wsize > WCMP_W'(MAX_DRIFT_WINDOW)) begin
         wsize = WCMP_W'(MAX_DRIFT_WINDOW);
      end
   end

   always_comb begin
      near_diff = DW'(avg_ff) - DW'(req_sample);
      near_mag  = near_diff[DW-1] ? DW'(-near_diff) : DW'(near_diff);
      near      = (count_ff == '0) || (near_mag < DW'(margin_ff));
      outl_next = {1'b0, outl_ff} + (wrs_pkg::OLIM_W + 1)'(1);

      remove    = (WCMP_W'(fill_ff) >= wsize);
      old_entry = DSUM_W'($signed(ram_rd_data));
      widx      = IDX_W'(head_ff) + IDX_W'(fill_ff);
      if (widx >= IDX_W'(MAX_DRIFT_WINDOW)) begin
         widx = widx - IDX_W'(MAX_DRIFT_WINDOW);
      end
      head_inc  = (head_ff == HEAD_W'(MAX_DRIFT_WINDOW - 1)) ? '0 : head_ff + HEAD_W'(1);

      tail      = div_quotient[SW-1:0];
      stab_avg  = (count_ff == '0) ? sample_ff : avg_ff;
      dcalc     = DW'(tail) - DW'(stab_avg);
      dmag      = dcalc[DW-1] ? DW'(-dcalc) : DW'(dcalc);
   end

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      sum_in         = sum_ff;
      count_in       = count_ff;
      avg_in         = avg_ff;
      outl_in        = outl_ff;
      dsum_in        = dsum_ff;
      fill_in        = fill_ff;
      head_in        = head_ff;
      sample_in      = sample_ff;
      dmode_in       = dmode_ff;
      rej_in         = rej_ff;
      lost_in        = lost_ff;
      det_in         = det_ff;
      dval_in        = dval_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_average_in = rsp_average_ff;
      rsp_stable_in  = rsp_stable_ff;
      rsp_rej_in     = rsp_rej_ff;
      rsp_lost_in    = rsp_lost_ff;
      rsp_det_in     = rsp_det_ff;
      rsp_drift_in   = rsp_drift_ff;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;
      ram_wr_addr    = widx[HEAD_W-1:0];
      div_start      = 1'b0;
      div_dividend   = NUM_W'(sum_ff);
      div_divisor    = DEN_W'(count_ff);

      unique case (state_ff)
         wrs_pkg::ST_IDLE: begin
            if (accept) begin
               sample_in = req_sample;
               rej_in    = 1'b0;
               lost_in   = 1'b0;
               det_in    = 1'b0;
               dval_in   = '0;
               if (!near) begin
                  rej_in   = 1'b1;
                  state_in = wrs_pkg::ST_FIN;
                  if (outl_next > {1'b0, olimit_ff}) begin
                     lost_in  = 1'b1;
                     sum_in   = '0;
                     count_in = '0;
                     outl_in  = '0;
                     dsum_in  = '0;
                     fill_in  = '0;
                     head_in  = '0;
                  end else begin
                     outl_in = outl_next[wrs_pkg::OLIM_W-1:0];
                  end
               end else begin
                  outl_in = '0;
                  if (PCMP_W'(count_ff) < pneed) begin
                     sum_in       = sum_ff + SUM_W'(req_sample);
                     count_in     = count_ff + CNT_W'(1);
                     dmode_in     = 1'b0;
                     div_start    = 1'b1;
                     div_dividend = NUM_W'(sum_in);
                     div_divisor  = DEN_W'(count_in);
                     state_in     = wrs_pkg::ST_DIV;
                  end else begin
                     ram_rd_en = 1'b1;
                     dmode_in  = 1'b1;
                     state_in  = wrs_pkg::ST_RING;
                  end
               end
            end
         end
         wrs_pkg::ST_RING: begin
            ram_wr_en = 1'b1;
            if (remove) begin
               dsum_in = dsum_ff - old_entry + DSUM_W'(sample_ff);
               head_in = head_inc;
               fill_in = fill_ff;
            end else begin
               dsum_in = dsum_ff + DSUM_W'(sample_ff);
               fill_in = fill_ff + FILL_W'(1);
            end
            if (WCMP_W'(fill_in) >= wsize) begin
               div_start    = 1'b1;
               div_dividend = NUM_W'(dsum_in);
               div_divisor  = DEN_W'(fill_in);
               state_in     = wrs_pkg::ST_DIV;
            end else begin
               state_in = wrs_pkg::ST_FIN;
            end
         end
         wrs_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = wrs_pkg::ST_FIN;
               if (!dmode_ff) begin
                  avg_in = div_quotient[SW-1:0];
               end else if (dmag > DW'(dlimit_ff) && dmag < DW'(margin_ff)) begin
                  det_in   = 1'b1;
                  dval_in  = dcalc;
                  lost_in  = 1'b1;
                  sum_in   = '0;
                  count_in = '0;
                  outl_in  = '0;
                  dsum_in  = '0;
                  fill_in  = '0;
                  head_in  = '0;
               end
            end
         end
         wrs_pkg::ST_FIN: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_average_in = (count_ff == '0) ? sample_ff : avg_ff;
               rsp_stable_in  = (PCMP_W'(count_ff) >= pneed);
               rsp_rej_in     = rej_ff;
               rsp_lost_in    = lost_ff;
               rsp_det_in     = det_ff;
               rsp_drift_in   = det_ff ? dval_ff : '0;
               state_in       = wrs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wrs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wrs_pkg::ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         outl_ff      <= '0;
         dsum_ff      <= '0;
         fill_ff      <= '0;
         head_ff      <= '0;
         sample_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         outl_ff      <= outl_in;
         dsum_ff      <= dsum_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         sample_ff    <= sample_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      avg_ff         <= avg_in;
      dmode_ff       <= dmode_in;
      rej_ff         <= rej_in;
      lost_ff        <= lost_in;
      det_ff         <= det_in;
      dval_ff        <= dval_in;
      rsp_average_ff <= rsp_average_in;
      rsp_stable_ff  <= rsp_stable_in;
      rsp_rej_ff     <= rsp_rej_in;
      rsp_lost_ff    <= rsp_lost_in;
      rsp_det_ff     <= rsp_det_in;
      rsp_drift_ff   <= rsp_drift_in;
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff  <= wrs_pkg::MARGIN_RST;
         dpoints_ff <= wrs_pkg::DP_RST;
         dwin_ff    <= wrs_pkg::DWIN_RST;
         dlimit_ff  <= wrs_pkg::DLIM_RST;
         olimit_ff  <= wrs_pkg::OLIM_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            wrs_pkg::CSR_MARGIN:        margin_ff  <= csr_data[wrs_pkg::MARGIN_W-1:0];
            wrs_pkg::CSR_DATA_POINTS:   dpoints_ff <= csr_data[wrs_pkg::DP_W-1:0];
            wrs_pkg::CSR_DRIFT_WINDOW:  dwin_ff    <= csr_data[wrs_pkg::DWIN_W-1:0];
            wrs_pkg::CSR_DRIFT_LIMIT:   dlimit_ff  <= csr_data[wrs_pkg::DLIM_W-1:0];
            wrs_pkg::CSR_OUTLIER_LIMIT: olimit_ff  <= csr_data[wrs_pkg::OLIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   wrs_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_DRIFT_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (sample_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   wrs_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_stall           = (state_ff != wrs_pkg::ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_average         = rsp_average_ff;
   assign rsp_stable          = rsp_stable_ff;
   assign rsp_sample_rejected = rsp_rej_ff;
   assign rsp_stability_lost  = rsp_lost_ff;
   assign rsp_drift_detected  = rsp_det_ff;
   assign rsp_drift           = rsp_drift_ff;

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == wrs_pkg::ST_DIV))
      else $error("divider finished outside the divide state");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (FILL_W + 1)'(fill_ff) <= (FILL_W + 1)'(MAX_DRIFT_WINDOW))
      else $error("drift ring fill exceeds ring depth");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (CNT_W + 1)'(count_ff) <= (CNT_W + 1)'(MAX_POINTS))
      else $error("accepted count exceeds its cap");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != wrs_pkg::ST_IDLE))
      else $error("accepted transaction did not start work");

endmodule
